/* src/msld_pkg.sv */
// Package for the mean smoothing and line detection block.
// Holds register indexes, limits and the front-to-back word type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package msld_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MinSize   = 5;
  localparam int unsigned MaxHeight = 4096;
  localparam logic [7:0]  LineMark  = 8'd255;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_STAGE     = 2'd3
  } reg_idx_t;

  // One classified word handed from the front to the back.
  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] col;
    logic       row_ge2;
    logic       row_ge4;
    logic       last;
  } front_word_t;
endpackage
`default_nettype wire

/* src/msld_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module msld_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/msld_front.sv */
// Front: accepts pixels, tracks column and row, classifies each word.
// Depends on msld_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msld_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic [7:0]         pixel,
  input  wire logic [8:0]         image_width,
  input  wire logic [12:0]        image_height,
  output msld_pkg::front_word_t   word
);
  import msld_pkg::*;

  localparam int CW = $clog2(MaxWidth);

  logic [CW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;
  logic [12:0]   w_eff, h_eff;
  logic [12:0]   col_x;

  always_comb begin
    w_eff = {4'd0, image_width};
    if (w_eff < 13'(MinSize)) w_eff = 13'(MinSize);
    if (w_eff > 13'(MaxWidth)) w_eff = 13'(MaxWidth);
    h_eff = image_height;
    if (h_eff < 13'(MinSize)) h_eff = 13'(MinSize);
    if (h_eff > 13'(MaxHeight)) h_eff = 13'(MaxHeight);
    col_x = 13'(col_r);
    word.pixel   = pixel;
    word.col     = 8'(col_r);
    word.row_ge2 = row_r >= 12'd2;
    word.row_ge4 = row_r >= 12'd4;
    word.last    = ({1'b0, row_r} == h_eff - 13'd1) && (col_x == w_eff - 13'd1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (col_x + 13'd1 >= w_eff) begin
        col_nxt = '0;
        if ({1'b0, row_r} + 13'd1 >= h_eff) row_nxt = '0;
        else row_nxt = row_r + 12'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end
endmodule
`default_nettype wire

/* src/msld_back.sv */
// Back: raw window and mean, smoothed window and line masks, output queue.
// Depends on msld_pkg and msld_ram.
`timescale 1ns / 1ps
`default_nettype none
module msld_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  msld_pkg::front_word_t word,
  input  wire logic signed [11:0] threshold,
  input  wire logic             stage_sel,
  output logic                  ready,
  output logic                  empty,
  input  wire logic             pop,
  output logic [7:0]            pixel_out,
  output logic                  last_of_image
);
  import msld_pkg::*;

  localparam int CW = $clog2(MaxWidth);

  // Stage A: line store read issued on accept; stage B: raw window + mean.
  logic        a_v_r;
  front_word_t a_w_r;
  logic [15:0] raw_rd;
  logic [7:0]  rw [3][3];
  logic [7:0]  rw_r [3][3];
  logic [11:0] sum;
  logic [7:0]  mean;
  logic        advance;

  // Output queue of depth 4 holds results so the pipe can drain while stalled.
  logic [8:0]  q_r [4];
  logic [2:0]  cnt_r;
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  inflight;

  msld_ram #(.Width(16), .Depth(MaxWidth)) u_raw (
    .clk, .we(a_v_r), .waddr(a_w_r.col[CW-1:0]),
    .wdata({raw_rd[7:0], a_w_r.pixel}),
    .re(in_valid), .raddr(word.col[CW-1:0]), .rdata(raw_rd)
  );

  // Raw store read issued in the same cycle as a write to that column: bypass.
  logic        byp_r;
  logic [15:0] byp_d_r;
  logic [15:0] raw_col;
  assign raw_col = byp_r ? byp_d_r : raw_rd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rw[i][0] = rw_r[i][1];
      rw[i][1] = rw_r[i][2];
    end
    rw[0][2] = raw_col[15:8];
    rw[1][2] = raw_col[7:0];
    rw[2][2] = a_w_r.pixel;
    sum = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) sum = sum + 12'(rw[i][j]);
    mean = 8'((24'(sum) * 24'd7282) >> 16);
  end

  // Stage B registers: mean and its control.
  logic        b_v_r;
  front_word_t b_w_r;
  logic [7:0]  b_mean_r;
  logic [7:0]  b_col_r;

  logic [15:0] sm_rd;
  logic        sbyp_r;
  logic [15:0] sbyp_d_r;
  logic [15:0] sm_col;
  logic [7:0]  sm_wc;
  assign sm_wc = a_w_r.col - 8'd1;

  msld_ram #(.Width(16), .Depth(MaxWidth)) u_smooth (
    .clk, .we(b_v_r), .waddr(b_col_r[CW-1:0]),
    .wdata({sm_col[7:0], b_mean_r}),
    .re(advance), .raddr(sm_wc[CW-1:0]), .rdata(sm_rd)
  );
  assign sm_col = sbyp_r ? sbyp_d_r : sm_rd;

  logic [7:0]  sw_r [3][3];
  logic [7:0]  sw [3][3];
  logic signed [13:0] tot, r0, r1, r2, r3;
  logic        hit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sw[i][0] = sw_r[i][1];
      sw[i][1] = sw_r[i][2];
    end
    sw[0][2] = sm_col[15:8];
    sw[1][2] = sm_col[7:0];
    sw[2][2] = b_mean_r;
    tot = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) tot = tot + 14'(sw[i][j]);
    r0 = 14'sd3 * 14'(10'(sw[1][0]) + 10'(sw[1][1]) + 10'(sw[1][2])) - tot;
    r1 = 14'sd3 * 14'(10'(sw[0][1]) + 10'(sw[1][1]) + 10'(sw[2][1])) - tot;
    r2 = 14'sd3 * 14'(10'(sw[0][2]) + 10'(sw[1][1]) + 10'(sw[2][0])) - tot;
    r3 = 14'sd3 * 14'(10'(sw[0][0]) + 10'(sw[1][1]) + 10'(sw[2][2])) - tot;
    hit = (r0 > 14'(threshold)) || (r1 > 14'(threshold)) ||
          (r2 > 14'(threshold)) || (r3 > 14'(threshold));
  end

  logic a_interior, b_emit;
  assign a_interior = a_w_r.row_ge2 && (a_w_r.col >= 8'd2);
  assign b_emit = b_v_r && (!stage_sel ||
                  (b_w_r.row_ge4 && (b_w_r.col >= 8'd4)));
  assign advance = a_v_r && a_interior;

  assign inflight = {2'b0, a_v_r} + {2'b0, b_v_r};
  assign ready = (cnt_r + inflight) < 3'd4;
  assign empty = (cnt_r == 3'd0);
  assign pixel_out = q_r[rp_r][7:0];
  assign last_of_image = q_r[rp_r][8];

  logic [7:0] res;
  assign res = stage_sel ? (hit ? LineMark : 8'd0) : b_mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0; b_v_r <= 1'b0; byp_r <= 1'b0; sbyp_r <= 1'b0;
      cnt_r <= '0; wp_r <= '0; rp_r <= '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          rw_r[i][j] <= '0;
          sw_r[i][j] <= '0;
        end
    end else begin
      a_v_r <= in_valid;
      byp_r <= in_valid && a_v_r && (word.col == a_w_r.col);
      b_v_r <= advance;
      sbyp_r <= advance && b_v_r && (sm_wc == b_col_r);
      if (a_v_r) rw_r <= rw;
      if (b_v_r) sw_r <= sw;
      if (b_emit) begin
        q_r[wp_r] <= {b_w_r.last, res};
        wp_r <= wp_r + 2'd1;
      end
      if (pop && !empty) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, b_emit} - {2'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) a_w_r <= word;
    byp_d_r <= {raw_col[7:0], a_w_r.pixel};
    sbyp_d_r <= {sm_col[7:0], b_mean_r};
    if (advance) begin
      b_w_r <= a_w_r;
      b_mean_r <= mean;
      b_col_r <= sm_wc;
    end
  end
endmodule
`default_nettype wire

/* src/mean_smooth_line_detect_top.sv */
// Top level: configuration registers, front classifier and back pipeline.
// Depends on msld_pkg, msld_front, msld_back and msld_ram.
//
//   channel | ports                          | handshake
//   input   | in_pixel_in                    | in_push / in_full
//   result  | out_pixel_out, out_last_of_image | out_pop / out_empty
//   config  | cfg_index, cfg_data            | cfg_we
//
// One pixel a cycle while in_full is low; a result reaches the output queue through
// the raw line store read and mean, then the smoothed line store read and masks.
// Reset clears counters, windows and the output queue; line stores need none.
// A four-word output queue absorbs stalls; in_full rises once queued and in-flight
// words reach four.
`timescale 1ns / 1ps
`default_nettype none
module mean_smooth_line_detect_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_pixel_in,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_pixel_out,
  output logic             out_last_of_image,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import msld_pkg::*;

  logic signed [11:0] thr_r;
  logic [8:0]         width_r;
  logic [12:0]        height_r;
  logic               stage_r;
  logic               ready, take;
  front_word_t        word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0; width_r <= 9'd200; height_r <= 13'd200; stage_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: thr_r    <= cfg_data[11:0];
        REG_WIDTH:     width_r  <= cfg_data[8:0];
        REG_HEIGHT:    height_r <= cfg_data;
        REG_STAGE:     stage_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_full = !ready;
  assign take = in_push && ready;

  msld_front u_front (
    .clk, .rst_n, .take, .pixel(in_pixel_in),
    .image_width(width_r), .image_height(height_r), .word
  );

  msld_back u_back (
    .clk, .rst_n, .in_valid(take), .word, .threshold(thr_r),
    .stage_sel(stage_r), .ready, .empty(out_empty), .pop(out_pop),
    .pixel_out(out_pixel_out), .last_of_image(out_last_of_image)
  );
endmodule
`default_nettype wire
